// ===== rtl/pidsr_pkg.sv =====
// ============================================================================
// pidsr_pkg: shared types and constants of the two-axis PID step-rate block
// Holds the sequencer states, the lane control word, the per-axis result
// and the fixed constants of the frequency and duty path.
// ============================================================================
package pidsr_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTEGRAL_GAIN   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DERIVATIVE_GAIN = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_TIME       = 2'd2;
    localparam int CFG_DATA_W = 24;

    localparam logic [15:0] INTEGRAL_GAIN_RESET   = 16'd0;
    localparam logic [15:0] DERIVATIVE_GAIN_RESET = 16'd0;
    localparam logic [23:0] STEP_TIME_RESET       = 24'd167772;

    // run flag threshold bands, whole units
    localparam logic [2:0] BAND_RESET = 3'd3;
    localparam logic [2:0] BAND_STOP  = 3'd4;
    localparam logic [2:0] BAND_START = 3'd2;

    // frequency limits
    localparam logic [13:0] FREQ_MAX_ENC = 14'd7000;
    localparam logic [13:0] FREQ_MAX_STD = 14'd9000;

    // duty = floor((freq * 42752 + 3125) / 6250), the Q4.12 form of 0.00167 * freq
    localparam int NUM_W      = 29;
    localparam int RECIP_W    = 20;
    localparam int DUTY_SHIFT = 32;
    localparam logic [15:0] DUTY_MUL  = 16'd42752;
    localparam logic [11:0] DUTY_BIAS = 12'd3125;
    localparam logic [12:0] DUTY_DIV  = 13'd6250;
    localparam logic [RECIP_W-1:0] DUTY_RECIP =
        RECIP_W'((64'd1 << DUTY_SHIFT) / 64'(DUTY_DIV));

    localparam int OUT_TDATA_W = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_INTEG,
        ST_KI,
        ST_SUM,
        ST_COMMIT,
        ST_FREQ,
        ST_RECIP,
        ST_FIX
    } seq_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic integ;
        logic ki;
        logic sum;
        logic commit;
        logic commit_pid;
        logic commit_manual;
        logic freq;
        logic recip;
        logic enc;
    } ctrl_t;

    typedef struct packed {
        logic [13:0] freq;
        logic [15:0] duty;
        logic        dir;
        logic        run;
    } lane_out_t;

endpackage

// ===== rtl/pidsr_lane.sv =====
// ============================================================================
// pidsr_lane: one axis of the PID step-rate controller
// Holds the axis state (integral, drive, band, run flag) and walks one word
// through the integral update, PID products, frequency clamp and duty scale.
// ============================================================================
module pidsr_lane #(
    parameter int ERROR_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pidsr_pkg::ctrl_t              ctrl,
    input  logic signed [ERROR_WIDTH-1:0] error,
    input  logic signed [ERROR_WIDTH-1:0] vel,
    input  logic                          lost,
    input  logic                          limit_up,
    input  logic                          limit_down,
    input  logic [15:0]                   integral_gain,
    input  logic [15:0]                   derivative_gain,
    input  logic [23:0]                   step_time,
    output pidsr_pkg::lane_out_t          result
);

    localparam int TW  = ERROR_WIDTH - 8;
    localparam int PW  = TW + 25;
    localparam int KDW = 23 + ERROR_WIDTH;

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        logic signed [47:0] r;
        if (v[49:47] == 3'b000 || v[49:47] == 3'b111)
        begin
            r = v[47:0];
        end
        else if (v[49])
        begin
            r = {1'b1, 47'd0};
        end
        else
        begin
            r = {1'b0, {47{1'b1}}};
        end
        return r;
    endfunction

    // word latches
    logic signed [ERROR_WIDTH-1:0] err_reg;
    logic [ERROR_WIDTH-1:0]        vel_mag_reg;
    logic                          vel_neg_reg;
    logic                          lost_reg;
    logic                          lim_up_reg;
    logic                          lim_down_reg;

    // pipeline of the PID products
    logic signed [PW-1:0] prod_reg;
    logic [22:0]          kd100_reg;
    logic signed [47:0]   kp_term_reg;
    logic signed [47:0]   manual_reg;
    logic signed [47:0]   integ_cand_reg;
    logic [KDW-1:0]       pd_reg;
    logic [39:0]          ki_lo_reg;
    logic [39:0]          ki_hi_reg;
    logic                 integ_neg_reg;
    logic signed [47:0]   kd_term_reg;
    logic signed [47:0]   drive_cand_reg;
    logic [13:0]          freq_reg;
    logic                 dir_reg;
    logic [pidsr_pkg::NUM_W-1:0] num_reg;
    logic [15:0]          q0_reg;

    // axis state
    logic signed [47:0] integral_reg;
    logic signed [47:0] drive_reg;
    logic [2:0]         band_reg;
    logic               running_reg;

    logic signed [ERROR_WIDTH-1:0] err_shr;
    logic signed [ERROR_WIDTH-1:0] tx_full;
    logic signed [TW-1:0]          tx;
    logic signed [24:0]            dt_s;
    logic signed [47:0]            tx48;
    logic signed [47:0]            tx10;
    logic signed [47:0]            e48;
    logic [22:0]                   kd23;
    logic [ERROR_WIDTH-1:0]        vel_mag_next;
    logic signed [PW-1:0]          prod_next;
    logic signed [48:0]            integ_sum;
    logic [47:0]                   integ_mag;
    logic [KDW-9:0]                kd_mag;
    logic [39:0]                   ki_mag;
    logic signed [49:0]            ki_term;
    logic signed [49:0]            pid_sum;
    logic [ERROR_WIDTH-1:0]        err_mag;
    logic                          nonneg;
    logic                          permitted;
    logic                          above;
    logic                          stop;
    logic [2:0]                    band_mid;
    logic                          run_mid;
    logic                          above_mid;
    logic                          start;
    logic [2:0]                    band_next;
    logic                          running_next;
    logic [47:0]                   drive_mag;
    logic [13:0]                   maxf;
    logic [13:0]                   freq_next;
    logic [pidsr_pkg::NUM_W+pidsr_pkg::RECIP_W-1:0] recip_prod;
    logic [pidsr_pkg::NUM_W-1:0]   rem;
    logic [15:0]                   duty;

    // truncate the error toward zero to whole units
    assign err_shr = err_reg >>> 8;
    assign tx_full = err_shr + {{(ERROR_WIDTH-1){1'b0}},
                                (err_reg[ERROR_WIDTH-1] & (|err_reg[7:0]))};
    assign tx      = tx_full[TW-1:0];
    assign dt_s    = {1'b0, step_time};
    assign prod_next = tx * dt_s;

    assign tx48 = 48'(tx);
    assign tx10 = (tx48 <<< 3) + (tx48 <<< 1);
    assign e48  = 48'(err_reg);
    assign kd23 = 23'(derivative_gain);

    assign vel_mag_next = vel[ERROR_WIDTH-1] ? (~vel + ERROR_WIDTH'(1)) : vel;

    assign integ_sum = 49'(integral_reg) + 49'(prod_reg);
    assign integ_mag = integ_cand_reg[47] ? 48'(-integ_cand_reg) : 48'(integ_cand_reg);
    assign kd_mag    = pd_reg[KDW-1:8];

    assign ki_mag  = ki_hi_reg + 40'(ki_lo_reg[39:24]);
    assign ki_term = integ_neg_reg ? -50'(ki_mag) : 50'(ki_mag);
    assign pid_sum = 50'(kp_term_reg) + ki_term + 50'(kd_term_reg);

    // run flag: stop pass, then start pass against the updated band
    assign err_mag   = err_reg[ERROR_WIDTH-1] ? (~err_reg + ERROR_WIDTH'(1)) : err_reg;
    assign nonneg    = lost_reg | ~err_reg[ERROR_WIDTH-1];
    assign permitted = lim_up_reg ? ~nonneg : (lim_down_reg ? nonneg : 1'b1);
    assign above     = err_mag > ERROR_WIDTH'({band_reg, 8'd0});
    assign stop      = ((~above | lost_reg) & running_reg) | ~permitted;
    assign band_mid  = stop ? pidsr_pkg::BAND_STOP : band_reg;
    assign run_mid   = stop ? 1'b0 : running_reg;
    assign above_mid = err_mag > ERROR_WIDTH'({band_mid, 8'd0});
    assign start     = above_mid & ~lost_reg & ~run_mid & permitted;
    assign band_next    = start ? pidsr_pkg::BAND_START : band_mid;
    assign running_next = start | run_mid;

    assign drive_mag = drive_reg[47] ? 48'(-drive_reg) : 48'(drive_reg);
    assign maxf      = ctrl.enc ? pidsr_pkg::FREQ_MAX_ENC : pidsr_pkg::FREQ_MAX_STD;
    assign freq_next = (drive_mag[47:8] > 40'(maxf)) ? maxf : drive_mag[21:8];

    assign recip_prod = (pidsr_pkg::NUM_W + pidsr_pkg::RECIP_W)'(num_reg)
                      * (pidsr_pkg::NUM_W + pidsr_pkg::RECIP_W)'(pidsr_pkg::DUTY_RECIP);

    // reciprocal estimate is low by at most one
    assign rem  = num_reg - pidsr_pkg::NUM_W'(q0_reg) * pidsr_pkg::NUM_W'(pidsr_pkg::DUTY_DIV);
    assign duty = q0_reg + 16'(rem >= pidsr_pkg::NUM_W'(pidsr_pkg::DUTY_DIV));

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            err_reg      <= error;
            vel_mag_reg  <= vel_mag_next;
            vel_neg_reg  <= vel[ERROR_WIDTH-1];
            lost_reg     <= lost;
            lim_up_reg   <= limit_up;
            lim_down_reg <= limit_down;
        end
        if (ctrl.mul)
        begin
            prod_reg    <= prod_next;
            kd100_reg   <= (kd23 << 6) + (kd23 << 5) + (kd23 << 2);
            kp_term_reg <= ctrl.enc ? (tx10 <<< 8) : (tx10 <<< 10);
            manual_reg  <= (e48 <<< 10) - (e48 <<< 4) - (e48 <<< 3);
        end
        if (ctrl.integ)
        begin
            integ_cand_reg <= sat48(50'(integ_sum));
            pd_reg         <= KDW'(kd100_reg) * KDW'(vel_mag_reg);
        end
        if (ctrl.ki)
        begin
            ki_lo_reg     <= 40'(integral_gain) * 40'(integ_mag[23:0]);
            ki_hi_reg     <= 40'(integral_gain) * 40'(integ_mag[47:24]);
            integ_neg_reg <= integ_cand_reg[47];
            kd_term_reg   <= vel_neg_reg ? -48'(kd_mag) : 48'(kd_mag);
        end
        if (ctrl.sum)
        begin
            drive_cand_reg <= sat48(pid_sum);
        end
        if (ctrl.freq)
        begin
            freq_reg <= freq_next;
            dir_reg  <= ~drive_reg[47];
            num_reg  <= pidsr_pkg::NUM_W'(freq_next) * pidsr_pkg::NUM_W'(pidsr_pkg::DUTY_MUL)
                      + pidsr_pkg::NUM_W'(pidsr_pkg::DUTY_BIAS);
        end
        if (ctrl.recip)
        begin
            q0_reg <= recip_prod[pidsr_pkg::DUTY_SHIFT+15:pidsr_pkg::DUTY_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            drive_reg    <= '0;
            band_reg     <= pidsr_pkg::BAND_RESET;
            running_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.commit_pid)
            begin
                integral_reg <= integ_cand_reg;
                drive_reg    <= drive_cand_reg;
            end
            else if (ctrl.commit_manual)
            begin
                drive_reg <= manual_reg;
            end
            if (ctrl.commit)
            begin
                band_reg    <= band_next;
                running_reg <= running_next;
            end
        end
    end

    assign result.freq = freq_reg;
    assign result.duty = duty;
    assign result.dir  = dir_reg;
    assign result.run  = running_reg;

endmodule

// ===== rtl/pidsr_ctrl.sv =====
// ============================================================================
// pidsr_ctrl: step sequencer shared by both axis lanes
// Takes one input word at a time, steps the lanes through their stages and
// decides whether the PID drive, the manual drive or neither is committed.
// ============================================================================
module pidsr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             auto_mode,
    input  logic             encoder_mode,
    input  logic             lost_x,
    input  logic             lost_y,
    input  logic             out_free,
    output pidsr_pkg::ctrl_t ctrl,
    output logic             push
);

    pidsr_pkg::seq_state_t state_reg;
    pidsr_pkg::seq_state_t state_next;

    logic auto_reg;
    logic enc_reg;
    logic lost_any_reg;
    logic accept;

    assign accept = s_tvalid & s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pidsr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            auto_reg     <= auto_mode;
            enc_reg      <= encoder_mode;
            lost_any_reg <= lost_x | lost_y;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        push       = 1'b0;
        ctrl       = '0;
        ctrl.enc   = enc_reg;
        unique case (state_reg)
            pidsr_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = pidsr_pkg::ST_MUL;
                end
            end
            pidsr_pkg::ST_MUL:
            begin
                ctrl.mul   = 1'b1;
                state_next = pidsr_pkg::ST_INTEG;
            end
            pidsr_pkg::ST_INTEG:
            begin
                ctrl.integ = 1'b1;
                state_next = pidsr_pkg::ST_KI;
            end
            pidsr_pkg::ST_KI:
            begin
                ctrl.ki    = 1'b1;
                state_next = pidsr_pkg::ST_SUM;
            end
            pidsr_pkg::ST_SUM:
            begin
                ctrl.sum   = 1'b1;
                state_next = pidsr_pkg::ST_COMMIT;
            end
            pidsr_pkg::ST_COMMIT:
            begin
                // a lost axis in auto mode holds integrals and drives of both axes
                ctrl.commit        = 1'b1;
                ctrl.commit_pid    = auto_reg & ~lost_any_reg;
                ctrl.commit_manual = ~auto_reg;
                state_next         = pidsr_pkg::ST_FREQ;
            end
            pidsr_pkg::ST_FREQ:
            begin
                ctrl.freq  = 1'b1;
                state_next = pidsr_pkg::ST_RECIP;
            end
            pidsr_pkg::ST_RECIP:
            begin
                ctrl.recip = 1'b1;
                state_next = pidsr_pkg::ST_FIX;
            end
            pidsr_pkg::ST_FIX:
            begin
                // hold until the output register can take the word
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = pidsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pidsr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/pidsr_merge.sv =====
// ============================================================================
// pidsr_merge: joins both lane results into one output word
// Packs the X and Y results and holds them in the output register until
// the downstream side takes the word.
// ============================================================================
module pidsr_merge (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  pidsr_pkg::lane_out_t                 res_x,
    input  pidsr_pkg::lane_out_t                 res_y,
    output logic                                 out_free,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pidsr_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    logic                                valid_reg;
    logic [pidsr_pkg::OUT_TDATA_W-1:0]   data_reg;

    assign out_free = ~valid_reg | m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= {res_y.run, res_x.run, res_y.dir, res_x.dir,
                         res_y.duty, res_x.duty, res_y.freq, res_x.freq};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ===== rtl/two_axis_pid_step_rate.sv =====
// ============================================================================
// two_axis_pid_step_rate: two-axis PID step-rate controller
// Turns X/Y position errors and velocities into step frequency, duty,
// direction and run flags per axis, with one lane per axis.
// ============================================================================
// Each input word is accepted in the idle state and then passes the eight
// steps of the lane sequencer (integral multiply, integral update, gain
// products, PID sum, state update, frequency clamp, duty reciprocal multiply
// and its correction); a new word is taken only after the last step of the
// previous one. The chain of registered multiplies in each lane sets this
// pace; both axes run in parallel lanes. The result word waits in the output
// register, which leaves the input side free to accept the next word; the
// last step stalls only while that register is still full and not being
// read. Configuration writes take effect at once and belong between words.
module two_axis_pid_step_rate #(
    parameter int ERROR_WIDTH = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // fields from bit 0: error_x, error_y, vel_x, vel_y (ERROR_WIDTH each),
    // lost_x, lost_y, auto_mode, encoder_mode, limit_up_x, limit_down_x,
    // limit_up_y, limit_down_y, zero fill to whole bytes
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((4*ERROR_WIDTH+8+7)/8)*8-1:0] s_tdata,
    // fields from bit 0: freq_x[14], freq_y[14], duty_x[16], duty_y[16],
    // dir_x, dir_y, run_x, run_y
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pidsr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                                cfg_wen,
    input  logic [pidsr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pidsr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int E  = ERROR_WIDTH;
    localparam int FB = 4 * E;

    logic [15:0] integral_gain_reg;
    logic [15:0] derivative_gain_reg;
    logic [23:0] step_time_reg;

    pidsr_pkg::ctrl_t     ctrl;
    pidsr_pkg::lane_out_t res_x;
    pidsr_pkg::lane_out_t res_y;
    logic                 push;
    logic                 out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_gain_reg   <= pidsr_pkg::INTEGRAL_GAIN_RESET;
            derivative_gain_reg <= pidsr_pkg::DERIVATIVE_GAIN_RESET;
            step_time_reg       <= pidsr_pkg::STEP_TIME_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                pidsr_pkg::CFG_INTEGRAL_GAIN:   integral_gain_reg   <= cfg_data[15:0];
                pidsr_pkg::CFG_DERIVATIVE_GAIN: derivative_gain_reg <= cfg_data[15:0];
                pidsr_pkg::CFG_STEP_TIME:       step_time_reg       <= cfg_data[23:0];
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    pidsr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .auto_mode    (s_tdata[FB+2]),
        .encoder_mode (s_tdata[FB+3]),
        .lost_x       (s_tdata[FB]),
        .lost_y       (s_tdata[FB+1]),
        .out_free     (out_free),
        .ctrl         (ctrl),
        .push         (push)
    );

    pidsr_lane #(
        .ERROR_WIDTH (ERROR_WIDTH)
    ) u_lane_x (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .error           (s_tdata[E-1:0]),
        .vel             (s_tdata[3*E-1:2*E]),
        .lost            (s_tdata[FB]),
        .limit_up        (s_tdata[FB+4]),
        .limit_down      (s_tdata[FB+5]),
        .integral_gain   (integral_gain_reg),
        .derivative_gain (derivative_gain_reg),
        .step_time       (step_time_reg),
        .result          (res_x)
    );

    pidsr_lane #(
        .ERROR_WIDTH (ERROR_WIDTH)
    ) u_lane_y (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .error           (s_tdata[2*E-1:E]),
        .vel             (s_tdata[4*E-1:3*E]),
        .lost            (s_tdata[FB+1]),
        .limit_up        (s_tdata[FB+6]),
        .limit_down      (s_tdata[FB+7]),
        .integral_gain   (integral_gain_reg),
        .derivative_gain (derivative_gain_reg),
        .step_time       (step_time_reg),
        .result          (res_y)
    );

    pidsr_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .res_x    (res_x),
        .res_y    (res_y),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
